FILE: src/note_driven_sine_tone_generator_assert.svh
// Assertion macros used by the top level of the tone generator.
`ifndef NOTE_DRIVEN_SINE_TONE_GENERATOR_ASSERT_SVH
`define NOTE_DRIVEN_SINE_TONE_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define NDSTG_ASSERT_NOW(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("tone generator check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define NDSTG_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("tone generator check failed");

`endif

FILE: src/ndstg_pkg.sv
// Shared types, constants and constant tables of the tone generator.
package ndstg_pkg;

   localparam int SAMPLE_RATE      = 48000;
   localparam int PHASE_BITS       = 32;
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int SINE_IDX_BITS    = $clog2(SINE_TABLE_DEPTH);
   localparam int QUARTER          = SINE_TABLE_DEPTH / 4;
   localparam int QUARTER_BITS     = SINE_IDX_BITS - 2;
   localparam int NOTE_COUNT       = 128;

   localparam int MAG_W    = 15;
   localparam int VEL_W    = 7;
   localparam int GAIN_W   = 21;
   localparam int PROD_W   = MAG_W + GAIN_W;
   localparam int QUOT_W   = 20;
   localparam int RECIP_W  = 21;
   localparam int RECIP_SH = 27;
   localparam int RPROD_W  = QUOT_W + RECIP_W;
   localparam int LEVEL_W  = RPROD_W - RECIP_SH;
   localparam int SAMPLE_W = 16;

   localparam logic [VEL_W-1:0]   VEL_FULL   = 7'd127;
   localparam logic [GAIN_W-1:0]  GAIN_Q16   = 21'd9830;
   localparam logic [PROD_W-1:0]  ROUND_BIAS = PROD_W'(127 * 32768);
   localparam logic [RECIP_W-1:0] RECIP_127  = RECIP_W'((1 << RECIP_SH) / 127);
   localparam logic [QUOT_W:0]    DIVISOR    = 21'd127;

   localparam logic [30:0] MANUAL_STEP_RESET = 31'd39370534;

   typedef enum logic [1:0] {
      REQ_TICK     = 2'd0,
      REQ_NOTE_ON  = 2'd1,
      REQ_NOTE_OFF = 2'd2,
      REQ_PANIC    = 2'd3
   } req_code_type;

   localparam logic REG_TONE_ENABLE = 1'b0;
   localparam logic REG_PHASE_STEP  = 1'b1;

   typedef struct packed {
      logic        tone_enable;
      logic [30:0] manual_phase_step;
   } cfg_type;

   typedef struct packed {
      logic [MAG_W-1:0]  mag;
      logic [GAIN_W-1:0] gain;
      logic              neg;
   } stage_b_type;

   localparam longint unsigned TOP_OCTAVE_Q16 [12] = '{
      64'd548668578, 64'd581294109, 64'd615859655, 64'd652480576,
      64'd691279090, 64'd732384684, 64'd775934544, 64'd822074013,
      64'd870957077, 64'd922746880, 64'd977616265, 64'd1035748353
   };

   // Quarter-wave sine entry i of QUARTER+1 points, Q0.15 magnitude.
   function automatic logic [MAG_W-1:0] sine_quarter(int unsigned i);
      longint unsigned u;
      longint unsigned u2;
      longint unsigned t;
      longint unsigned s;
      longint unsigned v;
      u  = (longint'(i) << 30) / QUARTER;
      u2 = (u * u) >> 30;
      t  = 64'd172272;
      t  = 64'd5026994 - ((u2 * t) >> 30);
      t  = 64'd85569306 - ((u2 * t) >> 30);
      t  = 64'd693598667 - ((u2 * t) >> 30);
      t  = 64'd1686629713 - ((u2 * t) >> 30);
      s  = (u * t) >> 30;
      v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[MAG_W-1:0];
   endfunction

   function automatic logic [QUARTER-1:0][MAG_W-1:0] build_sine_table();
      logic [QUARTER-1:0][MAG_W-1:0] tab;
      for (int i = 0; i < QUARTER; i++) begin
         tab[i] = sine_quarter(i);
      end
      return tab;
   endfunction

   function automatic logic [NOTE_COUNT-1:0][PHASE_BITS-1:0] build_note_steps();
      logic [NOTE_COUNT-1:0][PHASE_BITS-1:0] tab;
      longint unsigned f;
      longint unsigned st;
      int oct;
      int semi;
      int sh;
      for (int n = 0; n < NOTE_COUNT; n++) begin
         oct  = n / 12;
         semi = n % 12;
         sh   = 10 - oct;
         f    = TOP_OCTAVE_Q16[semi];
         if (sh > 0) begin
            f = (f + (64'd1 << (sh - 1))) >> sh;
         end
         st     = ((f << (PHASE_BITS - 16)) + 64'(SAMPLE_RATE / 2)) / SAMPLE_RATE;
         tab[n] = st[PHASE_BITS-1:0];
      end
      return tab;
   endfunction

   localparam logic [QUARTER-1:0][MAG_W-1:0] SINE_QUARTER = build_sine_table();
   localparam logic [MAG_W-1:0] SINE_PEAK = sine_quarter(QUARTER);
   localparam logic [NOTE_COUNT-1:0][PHASE_BITS-1:0] NOTE_STEP = build_note_steps();

endpackage

FILE: src/ndstg_csr.sv
// Configuration register file behind the APB-style port.
module ndstg_csr import ndstg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;
   logic    reg_sel;

   assign reg_sel = csr_paddr[2];
   assign wr_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_TONE_ENABLE: cfg_in.tone_enable       = csr_pwdata[0];
            REG_PHASE_STEP:  cfg_in.manual_phase_step = csr_pwdata[30:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tone_enable       <= 1'b0;
         cfg_ff.manual_phase_step <= MANUAL_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_TONE_ENABLE: csr_prdata = {31'd0, cfg_ff.tone_enable};
         REG_PHASE_STEP:  csr_prdata = {1'b0, cfg_ff.manual_phase_step};
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

FILE: src/ndstg_osc.sv
// Note state, phase accumulator and sine lookup stages.
module ndstg_osc import ndstg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_type,
   input  logic [6:0]       req_note,
   input  logic [6:0]       req_velocity,
   output logic             b_valid,
   output stage_b_type      b_data,
   input  logic             b_ready
);

   logic [PHASE_BITS-1:0]    phase_acc_ff, phase_acc_in;
   logic                     note_held_ff, note_held_in;
   logic [6:0]               held_note_ff, held_note_in;
   logic [VEL_W-1:0]         held_velocity_ff, held_velocity_in;

   logic                     a_valid_ff, a_valid_in;
   logic [SINE_IDX_BITS-1:0] a_k_ff, a_k_in;
   logic                     a_on_ff, a_on_in;
   logic [VEL_W-1:0]         a_vel_ff, a_vel_in;

   logic                     b_valid_ff;
   stage_b_type              b_data_ff, b_data_in;

   logic                     a_ready;
   logic                     b_load;
   logic                     accept;
   logic                     tick;
   logic [PHASE_BITS-1:0]    step;
   logic [1:0]               quad;
   logic [QUARTER_BITS:0]    rr;
   logic [MAG_W-1:0]         mag;

   // Each stage moves when it is empty or its successor takes its beat.
   assign b_load    = !b_valid_ff || b_ready;
   assign a_ready   = !a_valid_ff || b_load;
   assign req_stall = !a_ready;
   assign accept    = req_valid && a_ready;

   always_comb begin
      note_held_in     = note_held_ff;
      held_note_in     = held_note_ff;
      held_velocity_in = held_velocity_ff;
      phase_acc_in     = phase_acc_ff;
      tick             = 1'b0;
      step = note_held_ff ? NOTE_STEP[held_note_ff] : PHASE_BITS'(cfg.manual_phase_step);
      if (accept) begin
         case (req_code_type'(req_type))
            REQ_TICK: begin
               tick         = 1'b1;
               phase_acc_in = phase_acc_ff + step;
            end
            REQ_NOTE_ON: begin
               held_note_in     = req_note;
               held_velocity_in = req_velocity;
               note_held_in     = 1'b1;
            end
            REQ_NOTE_OFF: begin
               if (req_note == held_note_ff) begin
                  note_held_in = 1'b0;
               end
            end
            REQ_PANIC: begin
               note_held_in     = 1'b0;
               held_velocity_in = '0;
            end
            default: tick = 1'b0;
         endcase
      end
      a_valid_in = tick;
      a_k_in     = phase_acc_ff[PHASE_BITS-1 -: SINE_IDX_BITS];
      a_on_in    = note_held_ff || cfg.tone_enable;
      a_vel_in   = note_held_ff ? held_velocity_ff : VEL_FULL;
   end

   // Quarter-wave symmetry: odd quarters read the table backward, the
   // lower half wave is negated later in the gain pipeline.
   always_comb begin
      quad = a_k_ff[SINE_IDX_BITS-1 -: 2];
      if (quad[0]) begin
         rr = (QUARTER_BITS+1)'(QUARTER) - {1'b0, a_k_ff[QUARTER_BITS-1:0]};
      end else begin
         rr = {1'b0, a_k_ff[QUARTER_BITS-1:0]};
      end
      mag = rr[QUARTER_BITS] ? SINE_PEAK : SINE_QUARTER[rr[QUARTER_BITS-1:0]];
      b_data_in.mag  = a_on_ff ? mag : '0;
      b_data_in.gain = GAIN_Q16 * GAIN_W'(a_vel_ff);
      b_data_in.neg  = quad[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff     <= '0;
         note_held_ff     <= 1'b0;
         held_note_ff     <= '0;
         held_velocity_ff <= '0;
         a_valid_ff       <= 1'b0;
         b_valid_ff       <= 1'b0;
      end else begin
         phase_acc_ff     <= phase_acc_in;
         note_held_ff     <= note_held_in;
         held_note_ff     <= held_note_in;
         held_velocity_ff <= held_velocity_in;
         if (a_ready) begin
            a_valid_ff <= a_valid_in;
         end
         if (b_load) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_k_ff   <= a_k_in;
         a_on_ff  <= a_on_in;
         a_vel_ff <= a_vel_in;
      end
      if (b_load) begin
         b_data_ff <= b_data_in;
      end
   end

   assign b_valid = b_valid_ff;
   assign b_data  = b_data_ff;

endmodule

FILE: src/ndstg_gain.sv
// Gain pipeline: velocity scaling, divide by 127 and signed result register.
module ndstg_gain import ndstg_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                b_valid,
   input  stage_b_type         b_data,
   output logic                b_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SAMPLE_W-1:0] rsp_sample
);

   logic                c_valid_ff;
   logic [QUOT_W-1:0]   c_y_ff, c_y_in;
   logic                c_neg_ff;
   logic                d_valid_ff;
   logic [LEVEL_W-1:0]  d_q_ff, d_q_in;
   logic [QUOT_W-1:0]   d_y_ff;
   logic                d_neg_ff;
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;

   logic                c_load, d_load, e_load;
   logic [PROD_W-1:0]   prod;
   logic [RPROD_W-1:0]  rprod;
   logic [QUOT_W:0]     qm;
   logic [QUOT_W:0]     rem;
   logic [LEVEL_W-1:0]  level;

   assign e_load  = !rsp_valid_ff || !rsp_stall;
   assign d_load  = !d_valid_ff || e_load;
   assign c_load  = !c_valid_ff || d_load;
   assign b_ready = c_load;

   // Rounded scaling: floor((mag * gain + bias) / 2^16) first, then by 127.
   always_comb begin
      prod   = PROD_W'(b_data.mag) * PROD_W'(b_data.gain) + ROUND_BIAS;
      c_y_in = prod[PROD_W-1 -: QUOT_W];
   end

   // The reciprocal product lands on the quotient or one below it.
   always_comb begin
      rprod  = RPROD_W'(c_y_ff) * RPROD_W'(RECIP_127);
      d_q_in = rprod[RPROD_W-1:RECIP_SH];
   end

   always_comb begin
      qm    = ((QUOT_W+1)'(d_q_ff) << 7) - (QUOT_W+1)'(d_q_ff);
      rem   = {1'b0, d_y_ff} - qm;
      level = d_q_ff + ((rem >= DIVISOR) ? LEVEL_W'(1) : LEVEL_W'(0));
      rsp_sample_in = d_neg_ff ? -SAMPLE_W'(level) : SAMPLE_W'(level);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (c_load) begin
            c_valid_ff <= b_valid;
         end
         if (d_load) begin
            d_valid_ff <= c_valid_ff;
         end
         if (e_load) begin
            rsp_valid_ff <= d_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (c_load) begin
         c_y_ff   <= c_y_in;
         c_neg_ff <= b_data.neg;
      end
      if (d_load) begin
         d_q_ff   <= d_q_in;
         d_y_ff   <= c_y_ff;
         d_neg_ff <= c_neg_ff;
      end
      if (e_load) begin
         rsp_sample_ff <= rsp_sample_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

endmodule

FILE: src/note_driven_sine_tone_generator.sv
// Top level of the note-driven sine tone generator.
//
// Usage: every beat on the req_ channel is one command. A sample tick
// (req_type 0) produces exactly one beat on the rsp_ channel carrying a
// signed Q1.15 sample; note on, note off and panic beats only change the
// held note and velocity and produce no output beat.
// The oscillator runs at one beat per cycle while req_stall is low: a tick
// can be accepted on every rising edge at which req_stall is low.
// A tick's sample shows on rsp_valid after lookup, gain and divide stages.
// The phase accumulator and note state update at the accept edge, so the
// order of commands is the order of the beats.
// When the receiver stalls, the output register holds its sample and the
// internal stages keep filling; req_stall rises only once every stage
// behind the output register holds a beat.
// Synchronous reset clears the phase, the held note, the pipeline and
// sets tone_enable to 0 and the test-tone step to 440 Hz at 48 kHz.
// The APB-style csr_ port holds tone_enable at 0x0 and the test-tone
// phase step at 0x4; writes complete in the access cycle.
`include "note_driven_sine_tone_generator_assert.svh"
module note_driven_sine_tone_generator import ndstg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [6:0]  req_note,
   input  logic [6:0]  req_velocity,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [15:0] rsp_sample,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type         cfg;
   logic            b_valid;
   logic            b_ready;
   stage_b_type     b_data;
   logic [15:0]     sample;

   // Register file; its settings feed the oscillator combinationally.
   ndstg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Command decode, phase accumulation and quarter-wave sine lookup.
   ndstg_osc u_osc (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_note     (req_note),
      .req_velocity (req_velocity),
      .b_valid      (b_valid),
      .b_data       (b_data),
      .b_ready      (b_ready)
   );

   // Velocity gain with round-half-away-from-zero and the output register.
   ndstg_gain u_gain (
      .clock      (clock),
      .reset      (reset),
      .b_valid    (b_valid),
      .b_data     (b_data),
      .b_ready    (b_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_sample (sample)
   );

   assign rsp_sample = signed'(sample);

   // The input side stalls only when the lookup stage is full and blocked.
   `NDSTG_ASSERT_NOW(a_stall_needs_full_lookup, req_stall, b_valid && !b_ready)
   // A lookup beat that the gain pipeline refuses is kept, not dropped.
   `NDSTG_ASSERT_NEXT(a_lookup_beat_kept, b_valid && !b_ready, b_valid)
   // Nothing is offered on the output right after reset.
   `NDSTG_ASSERT_NOW(a_quiet_after_reset, $past(reset), !rsp_valid && !b_valid)

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the note-driven sine tone generator.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ndstg_pkg::*;

   // A run is cut short when this many cycles pass with no beat accepted on
   // either channel. The long receiver hold-off is the longest quiet stretch.
   localparam int unsigned WATCHDOG_LIMIT  = 4000;
   // This pause covers the depth of the pipeline with margin.
   localparam int unsigned DRAIN_CYCLES    = 16;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned PHASE_ITEMS     = 115;

   localparam logic [30:0] STEP_LOWEST  = 31'd1789570;
   localparam logic [30:0] STEP_HIGHEST = 31'd1789569706;
   localparam logic [30:0] STEP_ALL_SET = 31'h7FFF_FFFF;

   // Top octave (notes 120 to 131) in Hz, Q16. Lower octaves are derived by
   // shifting right with round half up.
   localparam bit [63:0] TOP_Q16 [12] = '{
      64'd548668578, 64'd581294109, 64'd615859655, 64'd652480576,
      64'd691279090, 64'd732384684, 64'd775934544, 64'd822074013,
      64'd870957077, 64'd922746880, 64'd977616265, 64'd1035748353
   };

   localparam bit [63:0] RATE_HZ   = 64'd48000;
   localparam bit [63:0] LEVEL_Q16 = 64'd9830;
   localparam bit [63:0] Q30_ONE   = 64'd1 << 30;

   // Tracks the oscillator state from the accepted command beats and keeps
   // the samples that the tick beats must produce, oldest first.
   class sine_voice;
      bit [31:0] phase;
      bit        held;
      bit [6:0]  held_key;
      bit [6:0]  held_vel;
      bit        tone_on;
      bit [30:0] tone_step;
      bit [15:0] expected_samples[$];
      int unsigned errors;

      function new();
         tone_step = MANUAL_STEP_RESET;
      endfunction

      function void report_error(string msg);
         errors++;
         if (errors <= 10) begin
            $display("MISMATCH: %s", msg);
         end
      endfunction

      function void write_register(int unsigned index, bit [31:0] value);
         if (index == int'(REG_TONE_ENABLE)) begin
            tone_on = value[0];
         end else if (index == int'(REG_PHASE_STEP)) begin
            tone_step = value[30:0];
         end
      endfunction

      // Equal-tempered phase increment of a MIDI note at the sample rate.
      function bit [31:0] key_step(bit [6:0] key);
         int unsigned sh;
         bit [63:0] f;
         sh = 10 - key / 12;
         f = TOP_Q16[key % 12];
         if (sh > 0) begin
            f = (f + (64'd1 << (sh - 1))) >> sh;
         end
         return 32'(((f << 16) + RATE_HZ / 2) / RATE_HZ);
      endfunction

      // Q1.15 sine at the top ten bits of the phase: a quarter-wave odd
      // polynomial in Q30, mirrored in the second and fourth quarters, negated in the
      // lower half wave.
      function int sine_at(bit [31:0] ph);
         bit [9:0] k;
         bit [63:0] u;
         bit [63:0] u2;
         bit [63:0] t;
         bit [63:0] s;
         bit [63:0] v;
         k = ph[31:22];
         u = 64'(k[7:0]) << 22;
         if (k[8]) begin
            u = Q30_ONE - u;
         end
         u2 = (u * u) >> 30;
         t = 64'd172272;
         t = 64'd5026994 - ((u2 * t) >> 30);
         t = 64'd85569306 - ((u2 * t) >> 30);
         t = 64'd693598667 - ((u2 * t) >> 30);
         t = 64'd1686629713 - ((u2 * t) >> 30);
         s = (u * t) >> 30;
         v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
         if (v > 64'd32767) begin
            v = 64'd32767;
         end
         return k[9] ? -int'(v) : int'(v);
      endfunction

      function void apply_command(req_code_type kind, bit [6:0] key, bit [6:0] vel);
         bit [31:0] step;
         bit [63:0] mag;
         bit [63:0] gain_vel;
         int s;
         int level;
         case (kind)
            REQ_NOTE_ON: begin
               held_key = key;
               held_vel = vel;
               held = 1'b1;
            end
            REQ_NOTE_OFF: begin
               if (key == held_key) begin
                  held = 1'b0;
               end
            end
            REQ_PANIC: begin
               held = 1'b0;
               held_vel = 7'd0;
            end
            REQ_TICK: begin
               step = held ? key_step(held_key) : 32'(tone_step);
               level = 0;
               if (held || tone_on) begin
                  s = sine_at(phase);
                  gain_vel = held ? 64'(held_vel) : 64'd127;
                  mag = 64'(s < 0 ? -s : s);
                  // Rounds half away from zero since the magnitude is scaled.
                  mag = (mag * LEVEL_Q16 * gain_vel + 64'd127 * 64'd32768) /
                        (64'd127 * 64'd65536);
                  level = s < 0 ? -int'(mag) : int'(mag);
               end
               phase += step;
               expected_samples.push_back(16'(level));
            end
            default: begin
            end
         endcase
      endfunction

      function void compare_sample(logic [15:0] got);
         bit [15:0] want;
         if (expected_samples.size() == 0) begin
            report_error($sformatf("sample %0d with no tick outstanding", $signed(got)));
            return;
         end
         want = expected_samples.pop_front();
         if (got !== want) begin
            report_error($sformatf("sample expected %0d, got %0d",
                                   $signed(want), $signed(got)));
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = REQ_TICK;
   logic [6:0]  req_note = 7'd0;
   logic [6:0]  req_velocity = 7'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic signed [15:0] rsp_sample;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   sine_voice voice = new();

   // Percentages that shape the traffic of the current phase of the run.
   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   // Set by the stimulus to make the receiver hold off; counted down below.
   int unsigned hold_cycles = 0;
   // Last note sent with a note on, so that most note offs hit the held note.
   bit [6:0] last_key = 7'd0;

   note_driven_sine_tone_generator i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_note     (req_note),
      .req_velocity (req_velocity),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_sample   (rsp_sample),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Both monitors sample at the rising edge, so they see the values that the
   // block saw. A result beat always belongs to a tick accepted at an earlier
   // edge, so checking before predicting keeps the queue order right.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         voice.compare_sample(rsp_sample);
      end
      if (!reset && req_valid && !req_stall) begin
         voice.apply_command(req_code_type'(req_type), req_note, req_velocity);
      end
   end

   // Receiver: stalls at random at the phase's rate, or holds off for a long
   // stretch when asked, so that the pipeline fills and stalls the sender.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // Watchdog: ends the run when neither channel has moved a beat for too long.
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // Offers one command beat, after an optional random gap, and returns at the
   // edge where it is accepted. The payload holds steady while stalled.
   task automatic send_beat(input req_code_type kind, input bit [6:0] key,
                            input bit [6:0] vel);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_note     <= key;
      req_velocity <= vel;
      do @(posedge clock); while (req_stall);
   endtask

   // APB write: setup cycle, then access cycle until pready.
   task automatic write_csr(input int unsigned index, input bit [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 3'(index * 4);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      voice.write_register(index, data);
   endtask

   // Waits until every tick has its sample, then lets the pipeline settle so
   // that trailing commands with no result have also gone through.
   task automatic wait_drained();
      while (voice.expected_samples.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One phase of random traffic under one register setting and one traffic
   // shape: mode 0 runs flat out, 1 idles the sender, 2 stalls the receiver,
   // 3 does both at a lighter rate. The unused register bits are random.
   task automatic run_phase(input int unsigned mode, input bit enable,
                            input bit [30:0] step, input bit squeeze);
      int unsigned pick;
      bit [6:0] key;
      wait_drained();
      write_csr(int'(REG_TONE_ENABLE), {31'($urandom), enable});
      write_csr(int'(REG_PHASE_STEP), {1'($urandom), step});
      idle_pct  = (mode == 1) ? 66 : (mode == 3) ? 34 : 0;
      stall_pct = (mode == 2) ? 66 : (mode == 3) ? 34 : 0;
      if (squeeze) begin
         hold_cycles = HOLD_OFF_CYCLES;
      end
      repeat (PHASE_ITEMS) begin
         pick = $urandom_range(0, 99);
         key  = 7'($urandom);
         // Mostly ticks so that samples flow; note offs mostly release the
         // held note, the rest are foreign and must be ignored.
         if (pick < 60) begin
            send_beat(REQ_TICK, key, 7'($urandom));
         end else if (pick < 76) begin
            last_key = key;
            send_beat(REQ_NOTE_ON, key, 7'($urandom));
         end else if (pick < 90) begin
            send_beat(REQ_NOTE_OFF, ($urandom_range(0, 3) != 0) ? last_key : key,
                      7'($urandom));
         end else begin
            send_beat(REQ_PANIC, key, 7'($urandom));
         end
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset settings, where the test tone is off.
      // Ticks with nothing held are silent but still move the phase.
      send_beat(REQ_TICK, 7'd0, 7'd0);
      send_beat(REQ_TICK, 7'd127, 7'd127);
      // A note on with zero velocity holds the note at zero amplitude.
      send_beat(REQ_NOTE_ON, 7'd0, 7'd0);
      send_beat(REQ_TICK, 7'd0, 7'd0);
      send_beat(REQ_TICK, 7'd0, 7'd0);
      // Highest note at full velocity.
      send_beat(REQ_NOTE_ON, 7'd127, 7'd127);
      send_beat(REQ_TICK, 7'd0, 7'd0);
      send_beat(REQ_TICK, 7'd0, 7'd0);
      // A note off for some other note leaves the held note sounding.
      send_beat(REQ_NOTE_OFF, 7'd5, 7'd0);
      send_beat(REQ_TICK, 7'd0, 7'd0);
      send_beat(REQ_NOTE_OFF, 7'd127, 7'd0);
      send_beat(REQ_TICK, 7'd0, 7'd0);
      send_beat(REQ_NOTE_ON, 7'd69, 7'd100);
      send_beat(REQ_TICK, 7'd0, 7'd0);
      // Panic releases the note and clears the velocity but keeps the note,
      // so the note off that follows has nothing left to release.
      send_beat(REQ_PANIC, 7'd0, 7'd0);
      send_beat(REQ_TICK, 7'd0, 7'd0);
      send_beat(REQ_NOTE_OFF, 7'd69, 7'd0);
      send_beat(REQ_NOTE_ON, 7'd60, 7'd64);
      send_beat(REQ_TICK, 7'd0, 7'd0);
      // Retrigger while a note is held.
      send_beat(REQ_NOTE_ON, 7'd72, 7'd1);
      send_beat(REQ_TICK, 7'd0, 7'd0);
      send_beat(REQ_PANIC, 7'd0, 7'd0);
      send_beat(REQ_TICK, 7'd0, 7'd0);
      req_valid <= 1'b0;

      // Random phases across the step range: reset value, both ends of the
      // working range, all bits set and zero, then random settings. The
      // first phase also carries the long receiver hold-off.
      run_phase(0, 1'b1, MANUAL_STEP_RESET, 1'b1);
      run_phase(1, 1'b1, STEP_LOWEST, 1'b0);
      run_phase(2, 1'b1, STEP_HIGHEST, 1'b0);
      run_phase(3, 1'b0, STEP_ALL_SET, 1'b0);
      run_phase(0, 1'b1, STEP_ALL_SET, 1'b0);
      run_phase(1, 1'b1, 31'd0, 1'b0);
      run_phase(2, 1'b0, 31'($urandom), 1'b0);
      run_phase(3, 1'b1, 31'($urandom), 1'b0);

      wait_drained();
      if (voice.errors == 0 && voice.expected_samples.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
